@@ rtl/mics_pkg.sv @@
// Shared types, constants and decode codes for the MIPS integer subset core.
// No dependencies; imported by the divider, queue, front, back and top modules.
`timescale 1ns / 1ps

package mics_pkg;

    // Data memory geometry: four byte lanes, each one byte wide
    localparam int MEM_BYTES  = 65536;
    localparam int MEM_AW     = $clog2(MEM_BYTES);
    localparam int LANE_DEPTH = MEM_BYTES / 4;
    localparam int LANE_AW    = MEM_AW - 2;
    localparam int LOAD_LIMIT = MEM_BYTES / 2;
    localparam logic [31:0] SP_INIT = 32'(MEM_BYTES - 16);

    localparam logic [23:0] STEP_LIMIT_RST = 24'd1000000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'b1;

    // Architectural register numbers
    localparam logic [4:0] REG_RET = 5'd2;
    localparam logic [4:0] REG_ARG = 5'd4;
    localparam logic [4:0] REG_SP  = 5'd29;
    localparam logic [4:0] REG_RA  = 5'd31;

    // Primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'h00;
    localparam logic [5:0] OPC_J       = 6'h02;
    localparam logic [5:0] OPC_JAL     = 6'h03;
    localparam logic [5:0] OPC_BEQ     = 6'h04;
    localparam logic [5:0] OPC_BNE     = 6'h05;
    localparam logic [5:0] OPC_ADDIU   = 6'h09;
    localparam logic [5:0] OPC_ANDI    = 6'h0C;
    localparam logic [5:0] OPC_ORI     = 6'h0D;
    localparam logic [5:0] OPC_XORI    = 6'h0E;
    localparam logic [5:0] OPC_LUI     = 6'h0F;
    localparam logic [5:0] OPC_LW      = 6'h23;
    localparam logic [5:0] OPC_SW      = 6'h2B;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SLLV = 6'h04;
    localparam logic [5:0] FN_SRLV = 6'h06;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADDU = 6'h20;
    localparam logic [5:0] FN_SUBU = 6'h22;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2A;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STOP_RUN   = 2'd0,
        STOP_BADOP = 2'd1,
        STOP_LIMIT = 2'd2
    } stop_t;

    typedef enum logic [4:0] {
        K_ADDU, K_SUBU, K_AND, K_OR, K_XOR, K_SLT, K_SLL, K_SRL, K_SLLV, K_SRLV,
        K_JR, K_MULT, K_DIV, K_MFHI, K_MFLO, K_ADDIU, K_ANDI, K_ORI, K_XORI,
        K_LUI, K_BEQ, K_BNE, K_J, K_JAL, K_LW, K_SW, K_BAD
    } kind_t;

    typedef enum logic [2:0] {
        BS_CLEAR, BS_IDLE, BS_START, BS_START2, BS_EXEC, BS_LW, BS_DIV, BS_DONE
    } back_state_t;

    // One classified command as it sits in the queue
    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] start_arg;
        logic [14:0] load_addr;
        logic [7:0]  load_byte;
        logic [31:0] instr;
        kind_t       kind;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic        wb;
    } q_entry_t;

    typedef struct packed {
        logic [31:0] code_size;
        logic [23:0] step_limit;
    } cfg_regs_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic clearing;
    } back_stat_t;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

@@ rtl/mics_ifs.sv @@
// Valid/ready channel interfaces: command input, status output, config write.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface mics_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] start_arg;
    logic [14:0] load_addr;
    logic [7:0]  load_byte;
    logic [31:0] instr_word;

    modport source(output valid, cmd, start_arg, load_addr, load_byte, instr_word,
                   input ready);
    modport sink(input valid, cmd, start_arg, load_addr, load_byte, instr_word,
                 output ready);
endinterface

interface mics_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        halted;
    logic [1:0]  halt_cause;
    logic [31:0] return_value;

    modport source(output valid, next_pc, halted, halt_cause, return_value,
                   input ready);
    modport sink(input valid, next_pc, halted, halt_cause, return_value,
                 output ready);
endinterface

interface mics_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/mics_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mics_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mics_div.sv @@
// Iterative unsigned restoring divider core, one quotient bit per cycle.
// Depends on mics_pkg (import only for house consistency of types).
`timescale 1ns / 1ps

module mics_div
    import mics_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [32:0] trial;

    // Restoring division step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next    = 32'(trial - {1'b0, dvs_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[31:0];
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/mics_fifo.sv @@
// Two-entry queue between the front (decode) and back (execute) parts.
// Depends on mics_pkg for the entry and status types.
`timescale 1ns / 1ps

module mics_fifo
    import mics_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t din,
    input  logic     pop,
    output q_entry_t dout,
    output q_stat_t  stat
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = slot_reg[rd_ptr_reg];
    assign stat.full  = cnt_reg == 2'd2;
    assign stat.empty = cnt_reg == 2'd0;

endmodule

@@ rtl/mics_front.sv @@
// Front part: accepts command transactions and classifies instruction words.
// Depends on mics_pkg and the mics_in_if interface.
`timescale 1ns / 1ps

module mics_front
    import mics_pkg::*;
(
    mics_in_if.sink    in_ch,
    input  q_stat_t    qstat,
    input  back_stat_t bstat,
    output logic       push,
    output q_entry_t   entry
);

    logic [5:0] opc;
    logic [5:0] fn;
    logic [4:0] rd;

    assign in_ch.ready = !qstat.full && !bstat.clearing;
    assign push        = in_ch.valid && in_ch.ready;

    assign opc = in_ch.instr_word[31:26];
    assign fn  = in_ch.instr_word[5:0];
    assign rd  = in_ch.instr_word[15:11];

    // Decode into an operation kind and writeback target
    always_comb
    begin
        entry.cmd       = cmd_t'(in_ch.cmd);
        entry.start_arg = in_ch.start_arg;
        entry.load_addr = in_ch.load_addr;
        entry.load_byte = in_ch.load_byte;
        entry.instr     = in_ch.instr_word;
        entry.rs        = in_ch.instr_word[25:21];
        entry.rt        = in_ch.instr_word[20:16];
        entry.dest      = in_ch.instr_word[20:16];
        entry.wb        = 1'b1;
        entry.kind      = K_BAD;
        case (opc)
            OPC_SPECIAL:
            begin
                entry.dest = rd;
                case (fn)
                    FN_ADDU: entry.kind = K_ADDU;
                    FN_SUBU: entry.kind = K_SUBU;
                    FN_AND:  entry.kind = K_AND;
                    FN_OR:   entry.kind = K_OR;
                    FN_XOR:  entry.kind = K_XOR;
                    FN_SLT:  entry.kind = K_SLT;
                    FN_SLL:  entry.kind = K_SLL;
                    FN_SRL:  entry.kind = K_SRL;
                    FN_SLLV: entry.kind = K_SLLV;
                    FN_SRLV: entry.kind = K_SRLV;
                    FN_MFHI: entry.kind = K_MFHI;
                    FN_MFLO: entry.kind = K_MFLO;
                    FN_JR:
                    begin
                        entry.kind = K_JR;
                        entry.wb   = 1'b0;
                    end
                    FN_MULT:
                    begin
                        entry.kind = K_MULT;
                        entry.wb   = 1'b0;
                    end
                    FN_DIV:
                    begin
                        entry.kind = K_DIV;
                        entry.wb   = 1'b0;
                    end
                    default:
                    begin
                        entry.kind = K_BAD;
                        entry.wb   = 1'b0;
                    end
                endcase
            end
            OPC_ADDIU: entry.kind = K_ADDIU;
            OPC_ANDI:  entry.kind = K_ANDI;
            OPC_ORI:   entry.kind = K_ORI;
            OPC_XORI:  entry.kind = K_XORI;
            OPC_LUI:   entry.kind = K_LUI;
            OPC_LW:    entry.kind = K_LW;
            OPC_JAL:
            begin
                entry.kind = K_JAL;
                entry.dest = REG_RA;
            end
            OPC_BEQ:
            begin
                entry.kind = K_BEQ;
                entry.wb   = 1'b0;
            end
            OPC_BNE:
            begin
                entry.kind = K_BNE;
                entry.wb   = 1'b0;
            end
            OPC_J:
            begin
                entry.kind = K_J;
                entry.wb   = 1'b0;
            end
            OPC_SW:
            begin
                entry.kind = K_SW;
                entry.wb   = 1'b0;
            end
            default:
            begin
                entry.kind = K_BAD;
                entry.wb   = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/mics_back.sv @@
// Back part: executes queued commands against register file and data memory.
// Depends on mics_pkg, mics_ram, mics_div and the mics_out_if interface.
`timescale 1ns / 1ps

module mics_back
    import mics_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_entry_t   head,
    input  q_stat_t    qstat,
    output logic       pop,
    input  cfg_regs_t  cfg,
    mics_out_if.source out_ch,
    output back_stat_t bstat
);

    back_state_t state_reg, state_next;
    q_entry_t    cur_reg, cur_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [23:0] step_reg, step_next;
    stop_t       stop_reg, stop_next;
    logic [31:0] gv_reg, gv_next;
    logic [31:0] r2_reg, r2_next;
    logic        na_reg, na_next;
    logic        nb_reg, nb_next;
    logic [1:0]  ea_lo_reg, ea_lo_next;
    logic [LANE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic        clr_report_reg, clr_report_next;
    logic        out_v_reg, out_v_next;
    logic [31:0] out_pc_reg, out_pc_next;
    stop_t       out_stop_reg, out_stop_next;
    logic [31:0] out_r2_reg, out_r2_next;

    // Register file ports (two copies, one per source operand)
    logic        gpr_we;
    logic [4:0]  gpr_waddr;
    logic [31:0] gpr_wdata;
    logic [4:0]  gpr_addr_a, gpr_addr_b;
    logic [31:0] gpr_rdata_a, gpr_rdata_b;

    // Data memory lane ports
    logic               ln_we    [4];
    logic [LANE_AW-1:0] ln_addr  [4];
    logic [7:0]         ln_wdata [4];
    logic [7:0]         ln_rdata [4];

    // Divider
    logic        div_start, div_done;
    logic [31:0] div_dvd, div_dvs, div_q, div_r;

    // Execute-stage values
    logic [31:0]        a, b, sx, ea, pc4, wval;
    logic signed [63:0] prod;
    logic               in_code, mem_ok, limit_hit, exec_go;
    logic [31:0]        ld_ba;
    logic               ld_ok;
    logic [31:0]        lw_word;
    logic [1:0]         k;

    assign a   = gv_reg[cur_reg.rs] ? gpr_rdata_a : 32'd0;
    assign b   = gv_reg[cur_reg.rt] ? gpr_rdata_b : 32'd0;
    assign sx  = sx16(cur_reg.instr[15:0]);
    assign ea  = a + sx;
    assign pc4 = pc_reg + 32'd4;
    assign prod = $signed(a) * $signed(b);

    assign in_code   = ({1'b0, pc_reg} + 33'd4) <= {1'b0, cfg.code_size};
    assign mem_ok    = ({1'b0, ea} + 33'd4) <= 33'(MEM_BYTES);
    assign limit_hit = step_reg >= cfg.step_limit;
    assign exec_go   = !limit_hit && in_code && (cur_reg.kind != K_BAD);

    assign ld_ba = 32'(head.load_addr);
    assign ld_ok = ld_ba < 32'(LOAD_LIMIT);

    // Little-endian reassembly from the four lanes
    assign lw_word = {ln_rdata[2'(ea_lo_reg + 2'd3)], ln_rdata[2'(ea_lo_reg + 2'd2)],
                      ln_rdata[2'(ea_lo_reg + 2'd1)], ln_rdata[ea_lo_reg]};

    // Result value for register-writing operations
    always_comb
    begin
        case (cur_reg.kind)
            K_ADDU:  wval = a + b;
            K_SUBU:  wval = a - b;
            K_AND:   wval = a & b;
            K_OR:    wval = a | b;
            K_XOR:   wval = a ^ b;
            K_SLT:   wval = {31'd0, $signed(a) < $signed(b)};
            K_SLL:   wval = b << cur_reg.instr[10:6];
            K_SRL:   wval = b >> cur_reg.instr[10:6];
            K_SLLV:  wval = b << a[4:0];
            K_SRLV:  wval = b >> a[4:0];
            K_MFHI:  wval = hi_reg;
            K_MFLO:  wval = lo_reg;
            K_ADDIU: wval = ea;
            K_ANDI:  wval = a & {16'd0, cur_reg.instr[15:0]};
            K_ORI:   wval = a | {16'd0, cur_reg.instr[15:0]};
            K_XORI:  wval = a ^ {16'd0, cur_reg.instr[15:0]};
            K_LUI:   wval = {cur_reg.instr[15:0], 16'd0};
            K_JAL:   wval = pc4 + 32'd4;
            default: wval = 32'd0;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, datapath updates and memory port control
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        pc_next         = pc_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        step_next       = step_reg;
        stop_next       = stop_reg;
        gv_next         = gv_reg;
        r2_next         = r2_reg;
        na_next         = na_reg;
        nb_next         = nb_reg;
        ea_lo_next      = ea_lo_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        out_v_next      = out_v_reg && !out_ch.ready;
        out_pc_next     = out_pc_reg;
        out_stop_next   = out_stop_reg;
        out_r2_next     = out_r2_reg;
        pop             = 1'b0;
        gpr_we          = 1'b0;
        gpr_waddr       = cur_reg.dest;
        gpr_wdata       = wval;
        div_start       = 1'b0;
        div_dvd         = a[31] ? 32'd0 - a : a;
        div_dvs         = b[31] ? 32'd0 - b : b;
        k               = 2'd0;
        for (int l = 0; l < 4; l++)
        begin
            ln_we[l]    = 1'b0;
            ln_addr[l]  = ea[MEM_AW-1:2] + LANE_AW'(2'(l) < ea[1:0]);
            ln_wdata[l] = 8'd0;
        end

        case (state_reg)
            BS_CLEAR:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    ln_we[l]   = 1'b1;
                    ln_addr[l] = clr_cnt_reg;
                end
                clr_cnt_next = clr_cnt_reg + LANE_AW'(1);
                if (clr_cnt_reg == LANE_AW'(LANE_DEPTH - 1))
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_report_reg ? BS_DONE : BS_IDLE;
                end
            end
            BS_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    case (head.cmd)
                        CMD_START: state_next = BS_START;
                        CMD_LOAD:
                        begin
                            // code byte goes straight into its lane
                            for (int l = 0; l < 4; l++)
                            begin
                                ln_addr[l]  = ld_ba[MEM_AW-1:2];
                                ln_wdata[l] = head.load_byte;
                                ln_we[l]    = ld_ok && (ld_ba[1:0] == 2'(l));
                            end
                            state_next = BS_DONE;
                        end
                        CMD_EXEC:
                            state_next = (stop_reg == STOP_RUN) ? BS_EXEC : BS_DONE;
                        default: state_next = BS_DONE;
                    endcase
                end
            end
            BS_START:
            begin
                gv_next   = '0;
                pc_next   = '0;
                hi_next   = '0;
                lo_next   = '0;
                step_next = '0;
                stop_next = STOP_RUN;
                r2_next   = '0;
                gpr_we    = 1'b1;
                gpr_waddr = REG_ARG;
                gpr_wdata = cur_reg.start_arg;
                state_next = BS_START2;
            end
            BS_START2:
            begin
                gpr_we          = 1'b1;
                gpr_waddr       = REG_SP;
                gpr_wdata       = SP_INIT;
                clr_report_next = 1'b1;
                state_next      = BS_CLEAR;
            end
            BS_EXEC:
            begin
                state_next = BS_DONE;
                ea_lo_next = ea[1:0];
                na_next    = a[31];
                nb_next    = b[31];
                if (limit_hit)
                begin
                    stop_next = STOP_LIMIT;
                end
                else if (in_code && (cur_reg.kind == K_BAD))
                begin
                    stop_next = STOP_BADOP;
                end
                else
                begin
                    step_next = step_reg + 24'd1;
                    if ((step_reg + 24'd1) >= cfg.step_limit)
                    begin
                        stop_next = STOP_LIMIT;
                    end
                end
                if (exec_go)
                begin
                    pc_next = pc4;
                    case (cur_reg.kind)
                        K_JR: pc_next = a;
                        K_BEQ:
                            if (a == b) pc_next = pc4 + {sx[29:0], 2'b00};
                        K_BNE:
                            if (a != b) pc_next = pc4 + {sx[29:0], 2'b00};
                        K_J, K_JAL:
                            pc_next = {pc4[31:28], cur_reg.instr[25:0], 2'b00};
                        K_MULT:
                        begin
                            lo_next = prod[31:0];
                            hi_next = prod[63:32];
                        end
                        K_DIV:
                            if (b != 32'd0)
                            begin
                                div_start  = 1'b1;
                                state_next = BS_DIV;
                            end
                        K_SW:
                            if (mem_ok)
                            begin
                                for (int l = 0; l < 4; l++)
                                begin
                                    k           = 2'(l) - ea[1:0];
                                    ln_we[l]    = 1'b1;
                                    ln_wdata[l] = 8'(b >> {k, 3'b000});
                                end
                            end
                        default:
                        begin
                        end
                    endcase
                    // a dropped lw still writes zero
                    if (cur_reg.kind == K_LW)
                    begin
                        if (mem_ok)
                        begin
                            state_next = BS_LW;
                        end
                        else
                        begin
                            gpr_we    = cur_reg.dest != 5'd0;
                            gpr_wdata = 32'd0;
                        end
                    end
                    else
                    begin
                        gpr_we = cur_reg.wb && (cur_reg.dest != 5'd0);
                    end
                end
            end
            BS_LW:
            begin
                gpr_we     = cur_reg.dest != 5'd0;
                gpr_wdata  = lw_word;
                state_next = BS_DONE;
            end
            BS_DIV:
            begin
                if (div_done)
                begin
                    lo_next    = (na_reg != nb_reg) ? 32'd0 - div_q : div_q;
                    hi_next    = na_reg ? 32'd0 - div_r : div_r;
                    state_next = BS_DONE;
                end
            end
            BS_DONE:
            begin
                if (!out_v_reg || out_ch.ready)
                begin
                    out_v_next    = 1'b1;
                    out_pc_next   = pc_reg;
                    out_stop_next = stop_reg;
                    out_r2_next   = r2_reg;
                    state_next    = BS_IDLE;
                end
            end
            default: state_next = BS_IDLE;
        endcase

        // Register writes mark the entry valid and track r2
        if (gpr_we)
        begin
            gv_next[gpr_waddr] = 1'b1;
            if (gpr_waddr == REG_RET)
            begin
                r2_next = gpr_wdata;
            end
        end
    end

    // Architectural and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= '0;
            hi_reg         <= '0;
            lo_reg         <= '0;
            step_reg       <= '0;
            stop_reg       <= STOP_RUN;
            gv_reg         <= '0;
            r2_reg         <= '0;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
            step_reg       <= step_next;
            stop_reg       <= stop_next;
            gv_reg         <= gv_next;
            r2_reg         <= r2_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            out_v_reg      <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        ea_lo_reg    <= ea_lo_next;
        out_pc_reg   <= out_pc_next;
        out_stop_reg <= out_stop_next;
        out_r2_reg   <= out_r2_next;
    end

    // Source operands are read while the command is popped
    assign gpr_addr_a = (state_reg == BS_IDLE) ? head.rs : gpr_waddr;
    assign gpr_addr_b = (state_reg == BS_IDLE) ? head.rt : gpr_waddr;

    mics_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_a (
        .clk   (clk),
        .we    (gpr_we),
        .addr  (gpr_addr_a),
        .wdata (gpr_wdata),
        .rdata (gpr_rdata_a)
    );

    mics_ram #(.WIDTH(32), .DEPTH(32)) u_gpr_b (
        .clk   (clk),
        .we    (gpr_we),
        .addr  (gpr_addr_b),
        .wdata (gpr_wdata),
        .rdata (gpr_rdata_b)
    );

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        mics_ram #(.WIDTH(8), .DEPTH(LANE_DEPTH)) u_lane (
            .clk   (clk),
            .we    (ln_we[g]),
            .addr  (ln_addr[g]),
            .wdata (ln_wdata[g]),
            .rdata (ln_rdata[g])
        );
    end

    mics_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign out_ch.valid        = out_v_reg;
    assign out_ch.next_pc      = out_pc_reg;
    assign out_ch.halt_cause   = out_stop_reg;
    assign out_ch.halted       = out_stop_reg != STOP_RUN;
    assign out_ch.return_value = out_r2_reg;
    assign bstat.clearing      = state_reg == BS_CLEAR;

endmodule

@@ rtl/mips_integer_subset_core.sv @@
// Flow: ALU, branch and store commands go from the queue to the execute and done states;
//   load-code, idle and halted-core commands go straight to done; lw and div can add a state.
// Start runs a memory clearing pass over all MEM_BYTES/4 lane addresses before reporting.
// Queueing: the two-entry queue can take new commands while the back part executes one.
// Reset: async active low; a memory clearing pass follows with input ready low.
// Depends on mics_pkg, the channel interfaces, front, queue and back modules.
`timescale 1ns / 1ps

module mips_integer_subset_core
    import mics_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mics_in_if.sink     in_ch,
    mics_out_if.source  out_ch,
    mics_cfg_if.sink    cfg_ch
);

    q_entry_t   entry, head;
    logic       push, pop;
    q_stat_t    qstat;
    back_stat_t bstat;
    cfg_regs_t  cfg_reg, cfg_next;

    // Configuration registers
    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_CODE_SIZE:  cfg_next.code_size  = cfg_ch.data;
                CFG_STEP_LIMIT: cfg_next.step_limit = cfg_ch.data[23:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_size  <= '0;
            cfg_reg.step_limit <= STEP_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mics_front u_front (
        .in_ch (in_ch),
        .qstat (qstat),
        .bstat (bstat),
        .push  (push),
        .entry (entry)
    );

    mics_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (entry),
        .pop   (pop),
        .dout  (head),
        .stat  (qstat)
    );

    mics_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .cfg    (cfg_reg),
        .out_ch (out_ch),
        .bstat  (bstat)
    );

`ifndef ASSERT_OFF
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.clearing |-> !in_ch.ready)
        else $error("transaction accepted during memory clearing pass");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full command queue");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.full |-> !qstat.empty)
        else $error("queue reports full and empty");

    a_halt_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.halted == (out_ch.halt_cause != STOP_RUN)))
        else $error("halted flag disagrees with halt cause");
`endif

endmodule
